/* hdl/copa_pkg.sv */
// ----------------------------------------------------------------------------
// copa_pkg
// Shared constants, register indexes and controller command type for the
// Copa congestion window update unit.
// ----------------------------------------------------------------------------
package copa_pkg;

  localparam int CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_SIZE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_VELOCITY     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DELTA_Q8     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RTT_WIN  = CFG_IDX_W'(3);

  localparam logic [15:0] SEGMENT_SIZE_RST = 16'd536;
  localparam logic [6:0]  VELOCITY_RST     = 7'd1;
  localparam logic [9:0]  DELTA_Q8_RST     = 10'd128;
  localparam logic [31:0] MIN_RTT_WIN_RST  = 32'd10000000;

  localparam logic [31:0] RTT_RESET_US    = 32'd1000000000;
  // 1500 bytes scaled by 256 for the q8 delta
  localparam logic [18:0] TARGET_BYTES_Q8 = 19'd384000;
  localparam logic [3:0]  FLOOR_SEGMENTS  = 4'd10;
  localparam logic [6:0]  VELOCITY_MAX    = 7'd64;

  // restoring divider, one quotient bit per cycle
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic load;      // capture input word
    logic est;       // update min / standing RTT estimates
    logic mul1;      // queue delay, step numerator, target product
    logic mul2;      // delay * window, saturation check, divider init
    logic mul3;      // times delta
    logic div_step;  // one quotient bit
    logic load_out;  // compute window, load output register
  } copa_cmd_t;

endpackage

/* hdl/copa_datapath.sv */
// ----------------------------------------------------------------------------
// copa_datapath
// RTT estimators, multiplier steps, bit-serial step divider and window
// update; all sequencing comes from the controller's command word.
// ----------------------------------------------------------------------------
module copa_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  copa_pkg::copa_cmd_t         cmd,
  input  logic                        cfg_we,
  input  logic [copa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                 cfg_data,
  input  logic [39:0]                 in_now_us,
  input  logic [31:0]                 in_rtt_sample_us,
  input  logic [31:0]                 in_window_in,
  output logic [31:0]                 out_window_out,
  output logic [31:0]                 out_min_rtt_us,
  output logic [31:0]                 out_standing_rtt_us,
  output logic [31:0]                 out_queue_delay_us,
  output logic                        out_increased
);
  import copa_pkg::*;

  // configuration
  logic [15:0] seg_r;
  logic [6:0]  vel_r;
  logic [9:0]  dq_raw_r;
  logic [31:0] min_win_r;

  // estimator state
  logic [31:0] min_val_r, stand_val_r, stand_win_r, last_delay_r;
  logic [39:0] min_stamp_r, stand_stamp_r;
  logic        min_vld_r, stand_vld_r;

  // working registers
  logic [39:0] now_r;
  logic [31:0] rtt_r, cwnd_r;
  logic [31:0] seg2_r;
  logic [41:0] den_r;
  logic [19:0] seg10_r;
  logic [31:0] delay_r, d_r;
  logic [45:0] num_r;
  logic [50:0] b_r;
  logic [63:0] dc_r;
  logic [73:0] prod_r;
  logic        sat_r, inc_r;
  logic [41:0] rem_r;
  logic [31:0] q_r;

  logic [31:0] out_window_r, out_min_r, out_stand_r, out_delay_r;
  logic        out_inc_r;

  logic [6:0]  vel;
  logic [9:0]  dq;
  logic        min_upd, stand_upd;
  logic [31:0] delay;
  logic [42:0] rem_sh;
  logic        q_bit;
  logic [31:0] step;
  logic [32:0] sum;
  logic [31:0] win;

  assign vel = (vel_r == 7'd0) ? 7'd1 : ((vel_r > VELOCITY_MAX) ? VELOCITY_MAX : vel_r);
  assign dq  = (dq_raw_r == 10'd0) ? 10'd1 : dq_raw_r;

  assign min_upd = !min_vld_r
                || ({1'b0, now_r} >= ({1'b0, min_stamp_r} + 41'(min_win_r)))
                || (rtt_r <= min_val_r);
  assign stand_upd = !stand_vld_r
                  || ({1'b0, now_r} >= ({1'b0, stand_stamp_r} + 41'(stand_win_r)))
                  || (rtt_r <= stand_val_r);

  assign delay = (stand_val_r > min_val_r) ? (stand_val_r - min_val_r) : 32'd0;

  assign rem_sh = {rem_r, q_r[31]};
  assign q_bit  = (rem_sh >= {1'b0, den_r});

  assign step = sat_r ? '1 : ((q_r == 32'd0) ? 32'd1 : q_r);
  assign sum  = {1'b0, cwnd_r} + {1'b0, step};

  always_comb begin
    if (inc_r) begin
      win = sum[32] ? '1 : sum[31:0];
    end else if (cwnd_r <= {12'd0, seg10_r}) begin
      win = {12'd0, seg10_r};
    end else if (cwnd_r > step) begin
      win = cwnd_r - step;
    end else begin
      win = 32'd0;
    end
  end

  // configuration and estimator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r         <= SEGMENT_SIZE_RST;
      vel_r         <= VELOCITY_RST;
      dq_raw_r      <= DELTA_Q8_RST;
      min_win_r     <= MIN_RTT_WIN_RST;
      min_val_r     <= RTT_RESET_US;
      min_stamp_r   <= '0;
      min_vld_r     <= 1'b0;
      stand_val_r   <= RTT_RESET_US;
      stand_stamp_r <= '0;
      stand_vld_r   <= 1'b0;
      stand_win_r   <= '0;
      last_delay_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SEGMENT_SIZE: seg_r     <= cfg_data[15:0];
          REG_VELOCITY:     vel_r     <= cfg_data[6:0];
          REG_DELTA_Q8:     dq_raw_r  <= cfg_data[9:0];
          REG_MIN_RTT_WIN:  min_win_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.est) begin
        if (min_upd) begin
          min_val_r   <= rtt_r;
          min_stamp_r <= now_r;
          min_vld_r   <= 1'b1;
        end
        if (stand_upd) begin
          stand_val_r   <= rtt_r;
          stand_win_r   <= rtt_r >> 1;
          stand_stamp_r <= now_r;
          stand_vld_r   <= 1'b1;
        end
      end
      if (cmd.mul1 && delay != 32'd0) begin
        last_delay_r <= delay;
      end
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_r  <= in_now_us;
      rtt_r  <= in_rtt_sample_us;
      cwnd_r <= in_window_in;
    end
    if (cmd.est) begin
      seg2_r  <= 32'(seg_r) * 32'(seg_r);
      den_r   <= 42'(dq) * 42'(cwnd_r);
      seg10_r <= 20'(seg_r) * 20'(FLOOR_SEGMENTS);
    end
    if (cmd.mul1) begin
      delay_r <= delay;
      d_r     <= (delay != 32'd0) ? delay : last_delay_r;
      num_r   <= {38'(seg2_r) * 38'(vel), 8'd0};
      b_r     <= 51'(TARGET_BYTES_Q8) * 51'(stand_val_r);
    end
    if (cmd.mul2) begin
      dc_r  <= 64'(d_r) * 64'(cwnd_r);
      // quotient reaches 2^32 exactly when num / 2^32 >= den
      sat_r <= ({28'd0, num_r[45:32]} >= den_r);
      rem_r <= {28'd0, num_r[45:32]};
      q_r   <= num_r[31:0];
    end
    if (cmd.mul3) begin
      prod_r <= 74'(dc_r) * 74'(dq);
    end
    if (cmd.div_step) begin
      rem_r <= q_bit ? 42'(rem_sh - {1'b0, den_r}) : rem_sh[41:0];
      q_r   <= {q_r[30:0], q_bit};
      // d <= b / a is tested as d * a <= b
      inc_r <= (d_r == 32'd0) ? (cwnd_r == 32'd0) : (prod_r <= {23'd0, b_r});
    end
    if (cmd.load_out) begin
      out_window_r <= win;
      out_min_r    <= min_val_r;
      out_stand_r  <= stand_val_r;
      out_delay_r  <= delay_r;
      out_inc_r    <= inc_r;
    end
  end

  assign out_window_out      = out_window_r;
  assign out_min_rtt_us      = out_min_r;
  assign out_standing_rtt_us = out_stand_r;
  assign out_queue_delay_us  = out_delay_r;
  assign out_increased       = out_inc_r;

endmodule

/* hdl/copa_ctrl.sv */
// ----------------------------------------------------------------------------
// copa_ctrl
// Sequencer for one ACK: estimate, three multiply steps, 32 divider steps,
// then the output load, held back while the output word is not taken.
// ----------------------------------------------------------------------------
module copa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output copa_pkg::copa_cmd_t cmd
);
  import copa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_EST, S_MUL1, S_MUL2, S_MUL3, S_DIV, S_FIN
  } state_t;

  state_t               state_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 out_valid_r;
  logic                 fire;

  assign fire      = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd          = '0;
    cmd.load     = (state_r == S_IDLE) && in_valid;
    cmd.est      = (state_r == S_EST);
    cmd.mul1     = (state_r == S_MUL1);
    cmd.mul2     = (state_r == S_MUL2);
    cmd.mul3     = (state_r == S_MUL3);
    cmd.div_step = (state_r == S_DIV);
    cmd.load_out = (state_r == S_FIN) && fire;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: if (in_valid) state_r <= S_EST;
        S_EST:  state_r <= S_MUL1;
        S_MUL1: state_r <= S_MUL2;
        S_MUL2: state_r <= S_MUL3;
        S_MUL3: begin
          state_r <= S_DIV;
          cnt_r   <= '0;
        end
        S_DIV: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) state_r <= S_FIN;
        end
        S_FIN:  if (fire) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd)) else $error("more than one datapath command active");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("output word overwritten before taken");

  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL3) |=> (state_r == S_DIV && cnt_r == '0))
    else $error("divider did not start at step zero");

  a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_EST && !in_ready))
    else $error("accepted word not followed by estimate step");

endmodule

/* hdl/copa_cwnd_update_unit.sv */
// ----------------------------------------------------------------------------
// copa_cwnd_update_unit
// Copa congestion window update, one ACK word in, one result word out.
//
//   channel  handshake            payload
//   in       in_valid/in_ready    in_now_us, in_rtt_sample_us, in_window_in
//   out      out_valid/out_ready  out_window_out, out_min_rtt_us,
//                                 out_standing_rtt_us, out_queue_delay_us,
//                                 out_increased
//   cfg      cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
// An ACK passes from accept to the next accept through 1 estimate step,
// 3 multiply steps, the bit-serial step divider, 1 output load and the
// idle state. The result is valid once the output load has run.
// Reset is synchronous; no clearing pass, the unit is ready right after.
// A stalled output holds the finished word; the next ACK is computed and
// waits in its last step until the output register frees.
// ----------------------------------------------------------------------------
module copa_cwnd_update_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [39:0]                 in_now_us,
  input  logic [31:0]                 in_rtt_sample_us,
  input  logic [31:0]                 in_window_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [31:0]                 out_window_out,
  output logic [31:0]                 out_min_rtt_us,
  output logic [31:0]                 out_standing_rtt_us,
  output logic [31:0]                 out_queue_delay_us,
  output logic                        out_increased,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [copa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                 cfg_data
);
  import copa_pkg::*;

  copa_cmd_t cmd;

  assign cfg_ready = 1'b1;

  copa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  copa_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .cfg_we              (cfg_valid && cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_now_us           (in_now_us),
    .in_rtt_sample_us    (in_rtt_sample_us),
    .in_window_in        (in_window_in),
    .out_window_out      (out_window_out),
    .out_min_rtt_us      (out_min_rtt_us),
    .out_standing_rtt_us (out_standing_rtt_us),
    .out_queue_delay_us  (out_queue_delay_us),
    .out_increased       (out_increased)
  );

endmodule
